### hdl/lvs_pkg.sv
// ----------------------------------------------------------------------------
// lvs_pkg
// Shared types and constants of the Levenshtein similarity block.
// ----------------------------------------------------------------------------
package lvs_pkg;

  localparam int FUNC_W = 2;
  localparam int CH_W   = 8;
  localparam int DIST_W = 7;
  localparam int SIM_W  = 17;

  // Command selectors carried in the func field.
  localparam logic [FUNC_W-1:0] FUNC_APPEND_A = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND_B = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_CELL,
    ST_DIV,
    ST_EMIT
  } lvs_state_t;

endpackage

### hdl/lvs_if.sv
// ----------------------------------------------------------------------------
// lvs_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface lvs_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [lvs_pkg::FUNC_W-1:0] func;
  logic [lvs_pkg::CH_W-1:0]   ch;

  modport source (output valid, output func, output ch, input ready);
  modport sink   (input valid, input func, input ch, output ready);
endinterface

interface lvs_res_if;
  logic                      valid;
  logic                      ready;
  logic [lvs_pkg::DIST_W-1:0] distance;
  logic [lvs_pkg::SIM_W-1:0]  similarity;
  logic                      both_empty;
  logic                      overflow;

  modport source (output valid, output distance, output similarity,
                  output both_empty, output overflow, input ready);
  modport sink   (input valid, input distance, input similarity,
                  input both_empty, input overflow, output ready);
endinterface

### hdl/lvs_ram.sv
// ----------------------------------------------------------------------------
// lvs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/levenshtein_similarity.sv
// ----------------------------------------------------------------------------
// levenshtein_similarity
// Unit-cost Levenshtein distance and normalized similarity of two byte strings.
// ----------------------------------------------------------------------------
// Command words with func 0 or 1 append ch to the first or second string;
// characters beyond MAX_LEN are dropped and flag overflow. A func 2 word
// starts the compute: the block runs the dynamic programming sweep one cell
// per cycle along each row out of a cost-row RAM, one row per character of
// the first string, then a bit-serial divider forms
// similarity = floor((m - d) * 65536 / m), m the longer length, in 17 steps.
// A compute word occupies the block, which takes no command words, until its
// result is emitted; the cell rate is set by the single read and write port
// of the cost-row RAM. The result word waits in an output register, so
// appends for the next pair are taken while it is pending. Each compute word
// clears both strings and the overflow flag. With both strings empty the
// result has both_empty set and distance and similarity zero.
// Func 3 is accepted and ignored.
// ----------------------------------------------------------------------------
module levenshtein_similarity #(
  parameter int MAX_LEN = 64
) (
  input  logic      clk,
  input  logic      rst,
  lvs_cmd_if.sink   cmd,
  lvs_res_if.source res
);

  localparam int LW    = $clog2(MAX_LEN + 1);             // lengths, costs, row index
  localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1; // string address
  localparam int DW    = (LW > lvs_pkg::DIST_W) ? LW : lvs_pkg::DIST_W;
  localparam int CNT_W = $clog2(lvs_pkg::SIM_W + 1);

  lvs_pkg::lvs_state_t state, state_next;

  // String fill state
  logic [LW-1:0] len_a, len_b;
  logic          ov_seen;

  // Working copy of one compute
  logic [LW-1:0] n1, n2, m;
  logic          ov_hold, empty_hold;
  logic [LW-1:0] i, j;
  logic [LW-1:0] diag, left;
  logic [LW-1:0] lev_dist;
  logic [LW:0]   rem;
  logic [lvs_pkg::SIM_W-1:0] quo;
  logic [CNT_W-1:0] cnt;

  // RAM ports
  logic          a_we, a_re, b_we, b_re, c_we, c_re;
  logic [AW-1:0] a_raddr, b_raddr;
  logic [LW-1:0] c_raddr;
  logic [lvs_pkg::CH_W-1:0] a_rd, b_rd;
  logic [LW-1:0] c_rd;

  // Handshakes
  logic cmd_fire, res_free, is_compute;
  assign cmd.ready  = (state == lvs_pkg::ST_IDLE);
  assign cmd_fire   = cmd.valid && cmd.ready;
  assign is_compute = (cmd.func == lvs_pkg::FUNC_COMPUTE);
  assign res_free   = !res.valid || res.ready;

  // DP cell: minimum of delete, insert and substitute
  logic [LW-1:0] i_m1, above, best, len_max;
  logic [LW:0]   above1, left1, sub, min_ai, best_w;
  logic          mism, last_col, last_row;

  assign i_m1    = i - 1'b1;
  assign mism    = (a_rd != b_rd);
  // the first row reads its costs from the column index, not the RAM
  assign above   = (i == LW'(1)) ? j : c_rd;
  assign above1  = {1'b0, above} + 1'b1;
  assign left1   = {1'b0, left} + 1'b1;
  assign sub     = {1'b0, diag} + {{LW{1'b0}}, mism};
  assign min_ai  = (above1 < left1) ? above1 : left1;
  assign best_w  = (sub < min_ai) ? sub : min_ai;
  assign best    = best_w[LW-1:0];
  assign last_col = (j == n2);
  assign last_row = (i == n1);
  assign len_max = (len_a > len_b) ? len_a : len_b;

  // Divider step
  logic          ge;
  logic [LW:0]   r_sub;
  assign ge    = (rem >= {1'b0, m});
  assign r_sub = ge ? (rem - {1'b0, m}) : rem;

  // Distance saturation for wide MAX_LEN
  logic [DW-1:0] dist_ext;
  assign dist_ext = DW'(lev_dist);

  // --------------------------------------------------------------------------
  // State register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lvs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Next state and RAM controls
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    a_we    = 1'b0;
    b_we    = 1'b0;
    a_re    = 1'b0;
    b_re    = 1'b0;
    c_re    = 1'b0;
    c_we    = 1'b0;
    a_raddr = i_m1[AW-1:0];
    b_raddr = j[AW-1:0];
    c_raddr = j + 1'b1;
    case (state)
      lvs_pkg::ST_IDLE: begin
        if (cmd_fire) begin
          a_we = (cmd.func == lvs_pkg::FUNC_APPEND_A) && (len_a < LW'(MAX_LEN));
          b_we = (cmd.func == lvs_pkg::FUNC_APPEND_B) && (len_b < LW'(MAX_LEN));
          if (is_compute) begin
            if (len_max == '0) begin
              state_next = lvs_pkg::ST_EMIT;
            end else if (len_a == '0 || len_b == '0) begin
              state_next = lvs_pkg::ST_DIV;
            end else begin
              state_next = lvs_pkg::ST_ROW;
            end
          end
        end
      end
      lvs_pkg::ST_ROW: begin
        // fetch this row's character and the first column's operands
        a_re       = 1'b1;
        b_re       = 1'b1;
        c_re       = 1'b1;
        b_raddr    = '0;
        c_raddr    = LW'(1);
        state_next = lvs_pkg::ST_CELL;
      end
      lvs_pkg::ST_CELL: begin
        c_we = 1'b1;
        // prefetch the next column while this one is written
        b_re = !last_col;
        c_re = !last_col;
        if (last_col) begin
          state_next = last_row ? lvs_pkg::ST_DIV : lvs_pkg::ST_ROW;
        end
      end
      lvs_pkg::ST_DIV: begin
        if (cnt == CNT_W'(1)) begin
          state_next = lvs_pkg::ST_EMIT;
        end
      end
      lvs_pkg::ST_EMIT: begin
        if (res_free) begin
          state_next = lvs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lvs_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Fill counters, sweep and divider datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      len_a   <= '0;
      len_b   <= '0;
      ov_seen <= 1'b0;
    end else if (cmd_fire) begin
      case (cmd.func)
        lvs_pkg::FUNC_APPEND_A: begin
          if (a_we) len_a <= len_a + 1'b1;
          else      ov_seen <= 1'b1;
        end
        lvs_pkg::FUNC_APPEND_B: begin
          if (b_we) len_b <= len_b + 1'b1;
          else      ov_seen <= 1'b1;
        end
        lvs_pkg::FUNC_COMPUTE: begin
          // clear for the next pair; the compute works from its own copy
          len_a   <= '0;
          len_b   <= '0;
          ov_seen <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      lvs_pkg::ST_IDLE: begin
        if (cmd_fire && is_compute) begin
          n1         <= len_a;
          n2         <= len_b;
          m          <= len_max;
          ov_hold    <= ov_seen;
          empty_hold <= (len_max == '0);
          i          <= LW'(1);
          // one empty string: distance is the other length
          lev_dist   <= len_max;
          rem        <= '0;
          quo        <= '0;
          cnt        <= CNT_W'(lvs_pkg::SIM_W);
        end
      end
      lvs_pkg::ST_ROW: begin
        j    <= LW'(1);
        diag <= i_m1;
        left <= i;
      end
      lvs_pkg::ST_CELL: begin
        diag <= above;
        left <= best;
        if (last_col) begin
          i <= i + 1'b1;
          if (last_row) begin
            lev_dist <= best;
            rem      <= {1'b0, m - best};
          end
        end else begin
          j <= j + 1'b1;
        end
      end
      lvs_pkg::ST_DIV: begin
        quo <= {quo[lvs_pkg::SIM_W-2:0], ge};
        rem <= {r_sub[LW-1:0], 1'b0};
        cnt <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (state == lvs_pkg::ST_EMIT && res_free) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lvs_pkg::ST_EMIT && res_free) begin
      res.distance   <= (dist_ext > DW'(127)) ? lvs_pkg::DIST_W'(127)
                                              : dist_ext[lvs_pkg::DIST_W-1:0];
      res.similarity <= empty_hold ? '0 : quo;
      res.both_empty <= empty_hold;
      res.overflow   <= ov_hold;
    end
  end

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  lvs_ram #(.WIDTH(lvs_pkg::CH_W), .DEPTH(MAX_LEN)) u_str_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (len_a[AW-1:0]),
    .wdata (cmd.ch),
    .re    (a_re),
    .raddr (a_raddr),
    .rdata (a_rd)
  );

  lvs_ram #(.WIDTH(lvs_pkg::CH_W), .DEPTH(MAX_LEN)) u_str_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (len_b[AW-1:0]),
    .wdata (cmd.ch),
    .re    (b_re),
    .raddr (b_raddr),
    .rdata (b_rd)
  );

  lvs_ram #(.WIDTH(LW), .DEPTH(MAX_LEN + 1)) u_cost_row (
    .clk   (clk),
    .we    (c_we),
    .waddr (j),
    .wdata (best),
    .re    (c_re),
    .raddr (c_raddr),
    .rdata (c_rd)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cell_col: assert property (@(posedge clk) disable iff (rst)
    (state == lvs_pkg::ST_CELL) |-> (j >= LW'(1) && j <= n2 && i <= n1))
    else $error("sweep column or row out of range");

  a_compute_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && is_compute) |=> (len_a == '0 && len_b == '0 && !ov_seen))
    else $error("strings not cleared by compute");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == lvs_pkg::ST_DIV) |-> (rem < {m, 1'b0}))
    else $error("divider remainder out of range");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.both_empty) |-> (res.distance == '0 && res.similarity == '0))
    else $error("empty pair gave nonzero result");

  a_full_scale: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.both_empty) |->
      ((res.distance == '0) == (res.similarity == lvs_pkg::SIM_W'(65536))))
    else $error("similarity full scale does not match zero distance");

endmodule

### test/tb_levenshtein_similarity.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_levenshtein_similarity
// Self-checking bench for the Levenshtein similarity block. Command words
// build two strings and ask for a compute. A scoreboard redoes the edit
// distance and the Q1.16 similarity for every compute word the block takes,
// and compares each result word field by field. Both channels idle and stall
// at random, and the result side holds off for long stretches to back the
// block up.
// ----------------------------------------------------------------------------
module tb_levenshtein_similarity;

  localparam int CAPACITY      = 64;
  localparam int RANDOM_WORDS  = 1200;
  localparam int HOLD_CYCLES   = 600;
  // Slowest compute: a full first string against a full second string.
  localparam int DRAIN_CYCLES  = CAPACITY * (CAPACITY + 1) + 64;
  localparam logic [lvs_pkg::FUNC_W-1:0] FUNC_IGNORED = 2'd3;

  typedef struct {
    logic [lvs_pkg::DIST_W-1:0] distance;
    logic [lvs_pkg::SIM_W-1:0]  similarity;
    logic                       both_empty;
    logic                       overflow;
  } score_t;

  typedef enum int {TEXT_NARROW, TEXT_WIDE, TEXT_MUTATED} text_style_t;
  typedef enum int {EDIT_INSERT, EDIT_DELETE, EDIT_SUBST} edit_kind_t;
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_COMB, SINK_MOSTLY, SINK_HOLD} sink_mode_t;

  // --------------------------------------------------------------------------
  // Scoreboard: its own copy of both strings, their lengths and the dropped
  // character flag. A compute word turns that state into one expected score.
  // --------------------------------------------------------------------------
  class similarity_scoreboard;
    logic [lvs_pkg::CH_W-1:0] first_chars[CAPACITY];
    logic [lvs_pkg::CH_W-1:0] second_chars[CAPACITY];
    int unsigned     first_len;
    int unsigned     second_len;
    bit              chars_dropped;
    score_t          expected_scores[$];
    int unsigned     mismatches;
    int unsigned     scores_seen;

    function new();
      first_len     = 0;
      second_len    = 0;
      chars_dropped = 1'b0;
      mismatches    = 0;
      scores_seen   = 0;
    endfunction

    // Single-row sweep over the cost table.
    function int unsigned sweep_cost();
      int unsigned row[CAPACITY+1];
      int unsigned diag, above, best;
      int unsigned i, j;
      for (j = 0; j <= second_len; j++) row[j] = j;
      for (i = 1; i <= first_len; i++) begin
        diag   = row[0];
        row[0] = i;
        for (j = 1; j <= second_len; j++) begin
          above = row[j];
          best  = diag + ((first_chars[i-1] == second_chars[j-1]) ? 0 : 1);
          if (above + 1 < best) best = above + 1;
          if (row[j-1] + 1 < best) best = row[j-1] + 1;
          diag   = above;
          row[j] = best;
        end
      end
      return row[second_len];
    endfunction

    function void note_word(logic [lvs_pkg::FUNC_W-1:0] func, logic [lvs_pkg::CH_W-1:0] ch);
      score_t          s;
      int unsigned     longer, cost;
      longint unsigned scaled;
      case (func)
        lvs_pkg::FUNC_APPEND_A: begin
          if (first_len < CAPACITY) begin
            first_chars[first_len] = ch;
            first_len++;
          end else begin
            chars_dropped = 1'b1;
          end
        end
        lvs_pkg::FUNC_APPEND_B: begin
          if (second_len < CAPACITY) begin
            second_chars[second_len] = ch;
            second_len++;
          end else begin
            chars_dropped = 1'b1;
          end
        end
        lvs_pkg::FUNC_COMPUTE: begin
          longer = (first_len > second_len) ? first_len : second_len;
          if (longer == 0) begin
            s.distance   = '0;
            s.similarity = '0;
            s.both_empty = 1'b1;
          end else begin
            cost         = sweep_cost();
            scaled       = 64'(longer - cost);
            scaled       = (scaled << 16) / 64'(longer);
            s.distance   = (cost > 127) ? {lvs_pkg::DIST_W{1'b1}}
                                        : lvs_pkg::DIST_W'(cost);
            s.similarity = lvs_pkg::SIM_W'(scaled);
            s.both_empty = 1'b0;
          end
          s.overflow = chars_dropped;
          expected_scores.push_back(s);
          first_len     = 0;
          second_len    = 0;
          chars_dropped = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(score_t got);
      score_t want;
      scores_seen++;
      if (expected_scores.size() == 0) begin
        $display("%0t: result word with nothing expected: distance %0d similarity %0d",
                 $time, got.distance, got.similarity);
        mismatches++;
        return;
      end
      want = expected_scores.pop_front();
      if (got.distance !== want.distance) begin
        $display("%0t: distance expected %0d, actual %0d", $time, want.distance, got.distance);
        mismatches++;
      end
      if (got.similarity !== want.similarity) begin
        $display("%0t: similarity expected %0d, actual %0d",
                 $time, want.similarity, got.similarity);
        mismatches++;
      end
      if (got.both_empty !== want.both_empty) begin
        $display("%0t: both_empty expected %0b, actual %0b",
                 $time, want.both_empty, got.both_empty);
        mismatches++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow expected %0b, actual %0b", $time, want.overflow, got.overflow);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;

  lvs_cmd_if cmd_bus ();
  lvs_res_if res_bus ();

  similarity_scoreboard board = new();

  int burst_left;
  int words_sent;

  levenshtein_similarity #(
    .MAX_LEN(CAPACITY)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .res(res_bus)
  );

  // 2 ns period: low first, rising edges on odd nanoseconds.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // --------------------------------------------------------------------------
  // Command side. Each word goes out at a falling edge and counts as taken at
  // the first rising edge with ready high. Words come in bursts of random
  // length; between bursts drop valid for a random number of cycles.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [lvs_pkg::FUNC_W-1:0] func,
                           input logic [lvs_pkg::CH_W-1:0] ch);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
      repeat (gap) begin
        @(negedge clk);
        cmd_bus.valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    cmd_bus.valid = 1'b1;
    cmd_bus.func  = func;
    cmd_bus.ch    = ch;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    board.note_word(func, ch);
    if (func != FUNC_IGNORED) words_sent++;
  endtask

  task automatic send_text(input logic [lvs_pkg::FUNC_W-1:0] func, input string text);
    foreach (text[k]) send_word(func, text[k]);
  endtask

  // --------------------------------------------------------------------------
  // One random string pair followed by a compute. Most pairs are short so the
  // sweep stays quick; a few run past capacity to hit the drop path. Mutated
  // pairs keep the distance small so similarity lands across its range.
  // --------------------------------------------------------------------------
  task automatic run_random_pair();
    byte unsigned first_q[$];
    byte unsigned second_q[$];
    text_style_t  style;
    edit_kind_t   kind;
    int           n1, n2, pick, edits, pos, ia, ib;
    pick = $urandom_range(0, 99);
    n1   = $urandom_range(0, 12);
    n2   = $urandom_range(0, 12);
    if (pick < 6) begin
      n1 = $urandom_range(56, 72);
      n2 = $urandom_range(0, 72);
    end else if (pick < 10) begin
      n1 = 0;
    end else if (pick < 14) begin
      n2 = 0;
    end
    style = text_style_t'($urandom_range(0, 2));
    repeat (n1) begin
      first_q.push_back((style == TEXT_WIDE) ? 8'($urandom_range(0, 255))
                                             : 8'(8'h61 + $urandom_range(0, 3)));
    end
    if (style == TEXT_MUTATED && n1 != 0 && n2 != 0) begin
      second_q = first_q;
      edits    = $urandom_range(0, 4);
      repeat (edits) begin
        pos  = $urandom_range(0, second_q.size());
        kind = edit_kind_t'($urandom_range(0, 2));
        case (kind)
          EDIT_INSERT: second_q.insert(pos, 8'($urandom_range(0, 255)));
          EDIT_DELETE: if (pos < second_q.size()) second_q.delete(pos);
          default:     if (pos < second_q.size()) second_q[pos] = 8'($urandom_range(0, 255));
        endcase
      end
    end else begin
      repeat (n2) begin
        second_q.push_back((style == TEXT_WIDE) ? 8'($urandom_range(0, 255))
                                                : 8'(8'h61 + $urandom_range(0, 3)));
      end
    end

    // Interleave the two strings at random, with the odd ignored word mixed in.
    ia = 0;
    ib = 0;
    while (ia < first_q.size() || ib < second_q.size()) begin
      if ($urandom_range(0, 19) == 0) send_word(FUNC_IGNORED, 8'($urandom_range(0, 255)));
      if (ib >= second_q.size() || (ia < first_q.size() && $urandom_range(0, 1) == 1)) begin
        send_word(lvs_pkg::FUNC_APPEND_A, first_q[ia]);
        ia++;
      end else begin
        send_word(lvs_pkg::FUNC_APPEND_B, second_q[ib]);
        ib++;
      end
    end
    // Now and then leave the compute out so the strings carry into the next pair.
    if ($urandom_range(0, 29) != 0) begin
      send_word(lvs_pkg::FUNC_COMPUTE, 8'($urandom_range(0, 255)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed words, random pairs, drain, verdict.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    cmd_bus.valid = 1'b0;
    cmd_bus.func  = lvs_pkg::FUNC_APPEND_A;
    cmd_bus.ch    = '0;
    burst_left    = 0;
    words_sent    = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Both strings empty: flag set, similarity zero.
    send_word(lvs_pkg::FUNC_COMPUTE, 8'h00);
    // Exactly one string empty, each side in turn, with the byte extremes.
    send_word(lvs_pkg::FUNC_APPEND_A, 8'h00);
    send_word(lvs_pkg::FUNC_COMPUTE, 8'hFF);
    send_word(lvs_pkg::FUNC_APPEND_B, 8'hFF);
    send_word(lvs_pkg::FUNC_COMPUTE, 8'h00);
    // Identical strings, with an ignored selector in between.
    send_word(lvs_pkg::FUNC_APPEND_A, 8'h00);
    send_word(FUNC_IGNORED, 8'hA5);
    send_word(lvs_pkg::FUNC_APPEND_B, 8'h00);
    send_word(lvs_pkg::FUNC_COMPUTE, 8'h5A);
    // Textbook pair: distance 3 over a longer length of 7.
    send_text(lvs_pkg::FUNC_APPEND_A, "kitten");
    send_text(lvs_pkg::FUNC_APPEND_B, "sitting");
    send_word(lvs_pkg::FUNC_COMPUTE, 8'h00);

    words_sent = 0;
    while (words_sent < RANDOM_WORDS) run_random_pair();
    // Close the last string pair so no characters sit unchecked.
    send_word(lvs_pkg::FUNC_COMPUTE, 8'h00);
    @(negedge clk);
    cmd_bus.valid = 1'b0;

    // Wait for every expected score, then give the block time to show any
    // stray result word.
    while (board.expected_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.mismatches == 0) begin
      $display("** levenshtein_similarity: PASSED **");
    end else begin
      $display("** levenshtein_similarity: FAILED **");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side. Switch between stall patterns over spans of random length. Twice,
  // once enough results have come, hold ready low for a long stretch while
  // the command side keeps going: the pending result blocks the next compute
  // and the block has to stall its command input.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    sink_mode_t mode;
    int         span, tick, holds_done;
    res_bus.ready = 1'b0;
    tick          = 0;
    holds_done    = 0;
    forever begin
      mode = sink_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      if (holds_done < 2 && board.scores_seen >= 8 + 30 * holds_done) begin
        mode = SINK_HOLD;
        span = HOLD_CYCLES;
        holds_done++;
      end
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          SINK_OPEN:   res_bus.ready = 1'b1;
          SINK_COIN:   res_bus.ready = 1'($urandom_range(0, 1));
          SINK_COMB:   res_bus.ready = (tick % 4 == 0);
          SINK_MOSTLY: res_bus.ready = ($urandom_range(0, 7) != 0);
          default:     res_bus.ready = 1'b0;
        endcase
      end
    end
  end

  // Check each result word on the edge that takes it.
  always @(posedge clk) begin : take_result
    score_t got;
    if (!rst && res_bus.valid && res_bus.ready) begin
      got.distance   = res_bus.distance;
      got.similarity = res_bus.similarity;
      got.both_empty = res_bus.both_empty;
      got.overflow   = res_bus.overflow;
      board.check_result(got);
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #1_000_000;
    $display("** levenshtein_similarity: FAILED **");
    $finish;
  end

endmodule
